### hdl/virtual_page_residency_lru_macros.svh
// assertion macros for the page residency tracker
`ifndef VIRTUAL_PAGE_RESIDENCY_LRU_MACROS_SVH
`define VIRTUAL_PAGE_RESIDENCY_LRU_MACROS_SVH
`ifndef SYNTHESIS
`define VPR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VPR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VPR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define VPR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/vpr_pkg.sv
// ----------------------------------------------------------------------------
// vpr_pkg
// shared constants and types for the page residency tracker
// ----------------------------------------------------------------------------
package vpr_pkg;
   localparam int VIRTUAL_SIDE = 16;
   localparam int PHYS_SLOTS   = 16;
   localparam int PAGE_COUNT   = VIRTUAL_SIDE * VIRTUAL_SIDE;
   localparam int PAGE_W       = 8;
   localparam int SLOT_W       = 4;
   localparam int SLOT_CNT_W   = 5;
   localparam int MAP_W        = 5;
   localparam int STAT_W       = 9;
   localparam int FRAME_W      = 32;
   localparam int RAM_AW       = 8;

   localparam logic [1:0] OP_BEGIN_FRAME = 2'd0;
   localparam logic [1:0] OP_MARK        = 2'd1;
   localparam logic [1:0] OP_LOOKUP      = 2'd2;
   localparam logic [1:0] OP_REINIT      = 2'd3;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_HIT     = 3'd1;
   localparam logic [2:0] ST_FILL    = 3'd2;
   localparam logic [2:0] ST_EVICT   = 3'd3;
   localparam logic [2:0] ST_NO_SLOT = 3'd4;

   localparam logic [STAT_W-1:0] STAT_MAX = 9'd256;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request
      logic clr_start;   // start clearing sweep (marks or map)
      logic clr_map;     // sweep targets map (else marks)
      logic clr_both;    // sweep targets map and marks
      logic clr_step;
      logic map_rd;      // read map at request page
      logic mark_wr;
      logic scan_init;
      logic scan_step;
      logic do_hit;
      logic do_install;
      logic do_frame;
      logic do_reinit;
      logic mark_rd;     // read mark of scanned owner
      logic respond;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_last;
      logic       scan_last;
      logic       map_hit;
      logic       in_range;
      logic [1:0] op;
   } stat_type;
endpackage

### hdl/vpr_ram.sv
// ----------------------------------------------------------------------------
// vpr_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module vpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

### hdl/vpr_ctrl.sv
// ----------------------------------------------------------------------------
// vpr_ctrl
// sequencing state machine for the page residency tracker
// ----------------------------------------------------------------------------
`include "virtual_page_residency_lru_macros.svh"
module vpr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vpr_pkg::stat_type stat,
   output vpr_pkg::ctrl_type ctrl
);
   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECODE  = 4'd2;
   localparam logic [3:0] S_MAPRD   = 4'd3;
   localparam logic [3:0] S_MAPCHK  = 4'd4;
   localparam logic [3:0] S_SCAN    = 4'd5;
   localparam logic [3:0] S_SCANW   = 4'd6;
   localparam logic [3:0] S_DECIDE  = 4'd7;
   localparam logic [3:0] S_CLEAR   = 4'd8;
   localparam logic [3:0] S_RESP    = 4'd9;
   localparam logic [3:0] S_WAIT    = 4'd10;
   localparam logic [3:0] S_INITCLR = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       clr_map_ff, clr_map_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         clr_map_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_map_ff <= clr_map_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_map_in = clr_map_ff;
      ctrl       = '0;
      ctrl.clr_map = clr_map_ff;
      busy       = (state_ff != S_IDLE);
      case (state_ff)
         S_INIT: begin
            ctrl.clr_start = 1'b1;
            state_in       = S_INITCLR;
         end
         S_INITCLR: begin
            ctrl.clr_step = 1'b1;
            ctrl.clr_both = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               vpr_pkg::OP_BEGIN_FRAME: begin
                  ctrl.do_frame  = 1'b1;
                  ctrl.clr_start = 1'b1;
                  ctrl.clr_map   = 1'b0;
                  clr_map_in     = 1'b0;
                  state_in       = S_CLEAR;
               end
               vpr_pkg::OP_MARK: begin
                  ctrl.mark_wr = stat.in_range;
                  state_in     = S_RESP;
               end
               vpr_pkg::OP_REINIT: begin
                  ctrl.do_reinit = 1'b1;
                  ctrl.clr_start = 1'b1;
                  ctrl.clr_map   = 1'b1;
                  clr_map_in     = 1'b1;
                  state_in       = S_CLEAR;
               end
               default: begin
                  if (stat.in_range) begin
                     ctrl.map_rd = 1'b1;
                     state_in    = S_MAPRD;
                  end else begin
                     state_in = S_RESP;
                  end
               end
            endcase
         end
         S_MAPRD: begin
            state_in = S_MAPCHK;
         end
         S_MAPCHK: begin
            if (stat.map_hit) begin
               ctrl.do_hit = 1'b1;
               state_in    = S_RESP;
            end else begin
               ctrl.scan_init = 1'b1;
               ctrl.mark_rd   = 1'b1;
               state_in       = S_SCANW;
            end
         end
         S_SCANW: begin
            ctrl.mark_rd = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            ctrl.scan_step = 1'b1;
            ctrl.mark_rd   = 1'b1;
            if (stat.scan_last) state_in = S_DECIDE;
            else state_in = S_SCANW;
         end
         S_DECIDE: begin
            ctrl.do_install = 1'b1;
            state_in        = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_RESP;
         end
         S_CLEAR: begin
            ctrl.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_RESP;
         end
         S_RESP: begin
            ctrl.respond = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `VPR_ASSERT_IMP(a_busy_idle, clock, reset, state_ff == S_IDLE, !busy, "busy while idle")
   `VPR_ASSERT_NXT(a_load_decode, clock, reset, ctrl.load, state_ff == S_DECODE, "load skipped decode")
   `VPR_ASSERT_NXT(a_resp_idle, clock, reset, ctrl.respond, state_ff == S_IDLE, "respond not followed by idle")
endmodule

### hdl/vpr_datapath.sv
// ----------------------------------------------------------------------------
// vpr_datapath
// page map, request marks, slot table and frame statistics
// ----------------------------------------------------------------------------
`include "virtual_page_residency_lru_macros.svh"
module vpr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  vpr_pkg::ctrl_type                   ctrl,
   output vpr_pkg::stat_type                   stat,
   input  logic [1:0]                          req_operation,
   input  logic [vpr_pkg::PAGE_W-1:0]          req_page,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [vpr_pkg::SLOT_W-1:0]          rsp_physical_slot,
   output logic [vpr_pkg::PAGE_W-1:0]          rsp_evicted_page,
   output logic [vpr_pkg::STAT_W-1:0]          rsp_hit_count,
   output logic [vpr_pkg::STAT_W-1:0]          rsp_miss_count,
   output logic [vpr_pkg::STAT_W-1:0]          rsp_eviction_count,
   output logic [vpr_pkg::SLOT_CNT_W-1:0]      rsp_resident_count
);
   localparam int PW = vpr_pkg::PAGE_W;
   localparam int SW = vpr_pkg::SLOT_W;
   localparam int FW = vpr_pkg::FRAME_W;
   localparam int AW = vpr_pkg::RAM_AW;

   logic [1:0]    op_ff;
   logic [PW-1:0] page_ff;
   logic          in_range;

   logic [AW:0]   clr_cnt_ff;
   logic [SW-1:0] scan_idx_ff;

   logic [PW-1:0] owner_ff  [vpr_pkg::PHYS_SLOTS];
   logic          valid_ff  [vpr_pkg::PHYS_SLOTS];
   logic [FW-1:0] last_ff   [vpr_pkg::PHYS_SLOTS];
   logic [FW-1:0] frame_ff;
   logic [vpr_pkg::STAT_W-1:0] hits_ff, miss_ff, evict_ff;
   logic [vpr_pkg::SLOT_CNT_W-1:0] occ_ff;

   logic          found_ff, free_ff;
   logic [SW-1:0] pick_ff;
   logic [FW-1:0] best_ff;

   logic [2:0]    status_ff;
   logic [SW-1:0] slot_ff;
   logic [PW-1:0] evicted_ff;

   // evicted page is registered; its map entry is cleared in the cycle after install
   logic          evict_pend_ff;
   logic [PW-1:0] evict_page_ff;

   // map ram
   logic                       map_we;
   logic [AW-1:0]              map_addr;
   logic [vpr_pkg::MAP_W-1:0]  map_wd, map_rd;
   // mark ram
   logic                       mark_we;
   logic [AW-1:0]              mark_addr;
   logic                       mark_wd, mark_rd;

   logic clearing;
   assign clearing = ctrl.clr_step && !clr_cnt_ff[AW];
   assign in_range = ({1'b0, page_ff} < (PW+1)'(vpr_pkg::PAGE_COUNT));

   always_comb begin
      map_we   = 1'b0;
      map_addr = page_ff;
      map_wd   = '0;
      if (clearing && (ctrl.clr_map || ctrl.clr_both)) begin
         map_we   = 1'b1;
         map_addr = clr_cnt_ff[AW-1:0];
         map_wd   = (clr_cnt_ff[AW-1:0] == '0) ? vpr_pkg::MAP_W'(1) : '0;
      end else if (ctrl.do_install && found_ff) begin
         map_we   = 1'b1;
         map_addr = page_ff;
         map_wd   = vpr_pkg::MAP_W'(pick_ff) + vpr_pkg::MAP_W'(1);
      end else if (evict_pend_ff) begin
         map_we   = 1'b1;
         map_addr = evict_page_ff;
         map_wd   = '0;
      end
      mark_we   = 1'b0;
      mark_addr = page_ff;
      mark_wd   = 1'b1;
      if (clearing && (!ctrl.clr_map || ctrl.clr_both)) begin
         mark_we   = 1'b1;
         mark_addr = clr_cnt_ff[AW-1:0];
         mark_wd   = 1'b0;
      end else if (ctrl.mark_wr) begin
         mark_we = 1'b1;
      end else if (ctrl.mark_rd) begin
         mark_addr = ctrl.scan_init ? owner_ff[0] : owner_ff[scan_idx_ff];
      end
   end

   vpr_ram #(.WIDTH(vpr_pkg::MAP_W), .DEPTH(vpr_pkg::PAGE_COUNT)) u_map (
      .clock(clock), .wr_en(map_we), .addr(map_addr), .wr_data(map_wd), .rd_data(map_rd));
   vpr_ram #(.WIDTH(1), .DEPTH(vpr_pkg::PAGE_COUNT)) u_mark (
      .clock(clock), .wr_en(mark_we), .addr(mark_addr), .wr_data(mark_wd), .rd_data(mark_rd));

   logic map_hit;
   assign map_hit = (map_rd != '0) && ({1'b0, map_rd} <= (vpr_pkg::MAP_W+1)'(vpr_pkg::PHYS_SLOTS));

   assign stat.op        = op_ff;
   assign stat.in_range  = in_range;
   assign stat.map_hit   = map_hit;
   assign stat.clr_last  = clr_cnt_ff[AW];
   assign stat.scan_last = (scan_idx_ff == SW'(vpr_pkg::PHYS_SLOTS - 1));

   logic cand_ok;
   assign cand_ok = !mark_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff      <= '0;
         hits_ff       <= '0;
         miss_ff       <= '0;
         evict_ff      <= '0;
         occ_ff        <= vpr_pkg::SLOT_CNT_W'(1);
         rsp_valid     <= 1'b0;
         clr_cnt_ff    <= '0;
         evict_pend_ff <= 1'b0;
         for (int i = 0; i < vpr_pkg::PHYS_SLOTS; i++) begin
            valid_ff[i] <= (i == 0);
            owner_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
      end else begin
         rsp_valid <= ctrl.respond;
         if (ctrl.load) begin
            op_ff      <= req_operation;
            page_ff    <= req_page;
            status_ff  <= vpr_pkg::ST_DONE;
            slot_ff    <= '0;
            evicted_ff <= '0;
         end
         if (ctrl.clr_start) clr_cnt_ff <= '0;
         else if (clearing) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (ctrl.do_frame) begin
            if (frame_ff != '1) frame_ff <= frame_ff + 1'b1;
            hits_ff  <= '0;
            miss_ff  <= '0;
            evict_ff <= '0;
         end
         if (ctrl.do_reinit) begin
            occ_ff <= vpr_pkg::SLOT_CNT_W'(1);
            for (int i = 0; i < vpr_pkg::PHYS_SLOTS; i++) begin
               valid_ff[i] <= (i == 0);
               owner_ff[i] <= '0;
               last_ff[i]  <= (i == 0) ? frame_ff : '0;
            end
         end
         if (ctrl.do_hit) begin
            last_ff[SW'(map_rd - 1'b1)] <= frame_ff;
            if (hits_ff != vpr_pkg::STAT_MAX) hits_ff <= hits_ff + 1'b1;
            status_ff <= vpr_pkg::ST_HIT;
            slot_ff   <= SW'(map_rd - 1'b1);
         end
         if (ctrl.scan_init) begin
            if (miss_ff != vpr_pkg::STAT_MAX) miss_ff <= miss_ff + 1'b1;
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
            free_ff     <= 1'b0;
            pick_ff     <= '0;
            best_ff     <= '0;
         end
         if (ctrl.scan_step) begin
            if (!free_ff) begin
               if (!valid_ff[scan_idx_ff]) begin
                  free_ff  <= 1'b1;
                  found_ff <= 1'b1;
                  pick_ff  <= scan_idx_ff;
               end else if (cand_ok && (!found_ff || last_ff[scan_idx_ff] < best_ff)) begin
                  found_ff <= 1'b1;
                  pick_ff  <= scan_idx_ff;
                  best_ff  <= last_ff[scan_idx_ff];
               end
            end
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         evict_pend_ff <= 1'b0;
         if (ctrl.do_install) begin
            if (!found_ff) begin
               status_ff <= vpr_pkg::ST_NO_SLOT;
            end else begin
               if (free_ff) begin
                  status_ff <= vpr_pkg::ST_FILL;
                  occ_ff    <= occ_ff + 1'b1;
               end else begin
                  status_ff     <= vpr_pkg::ST_EVICT;
                  evicted_ff    <= owner_ff[pick_ff];
                  evict_pend_ff <= 1'b1;
                  evict_page_ff <= owner_ff[pick_ff];
                  if (evict_ff != vpr_pkg::STAT_MAX) evict_ff <= evict_ff + 1'b1;
               end
               valid_ff[pick_ff] <= 1'b1;
               owner_ff[pick_ff] <= page_ff;
               last_ff[pick_ff]  <= frame_ff;
               slot_ff           <= pick_ff;
            end
         end
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_physical_slot  = slot_ff;
   assign rsp_evicted_page   = evicted_ff;
   assign rsp_hit_count      = hits_ff;
   assign rsp_miss_count     = miss_ff;
   assign rsp_eviction_count = evict_ff;
   assign rsp_resident_count = occ_ff;

   `VPR_ASSERT_IMP(a_occ_max, clock, reset, 1'b1, occ_ff <= vpr_pkg::SLOT_CNT_W'(vpr_pkg::PHYS_SLOTS), "occupancy overflow")
   `VPR_ASSERT_IMP(a_evict_status, clock, reset, rsp_valid && rsp_status != vpr_pkg::ST_EVICT, rsp_evicted_page == '0, "evicted page without eviction")
   `VPR_ASSERT_NXT(a_hit_last, clock, reset, ctrl.do_hit, status_ff == vpr_pkg::ST_HIT, "hit not recorded")
endmodule

### hdl/virtual_page_residency_lru.sv
// mark_requested: decode then respond; lookup hit: decode, map read, map check, respond
// lookup miss: decode, map read and check, scan wait and step per slot, then install
// begin_frame and reset_to_initial sweep 256 table entries
// throughput: one transaction at a time, the next accepted at the edge that takes the result
// reset: busy high during reset and after it while both tables clear
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// virtual_page_residency_lru
// residency tracker for a virtual page cache with lru replacement
// ----------------------------------------------------------------------------
module virtual_page_residency_lru (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_operation,
   input  logic [vpr_pkg::PAGE_W-1:0]     req_page,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_status,
   output logic [vpr_pkg::SLOT_W-1:0]     rsp_physical_slot,
   output logic [vpr_pkg::PAGE_W-1:0]     rsp_evicted_page,
   output logic [vpr_pkg::STAT_W-1:0]     rsp_hit_count,
   output logic [vpr_pkg::STAT_W-1:0]     rsp_miss_count,
   output logic [vpr_pkg::STAT_W-1:0]     rsp_eviction_count,
   output logic [vpr_pkg::SLOT_CNT_W-1:0] rsp_resident_count
);
   vpr_pkg::ctrl_type ctrl;
   vpr_pkg::stat_type stat;

   vpr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .stat(stat), .ctrl(ctrl));

   vpr_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_operation(req_operation), .req_page(req_page),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_physical_slot(rsp_physical_slot), .rsp_evicted_page(rsp_evicted_page),
      .rsp_hit_count(rsp_hit_count), .rsp_miss_count(rsp_miss_count),
      .rsp_eviction_count(rsp_eviction_count), .rsp_resident_count(rsp_resident_count));
endmodule
